### rtl/dpvs_pkg.sv
`default_nettype none
package dpvs_pkg;
  localparam int NumElements  = 7;
  localparam int VecMax       = 7;
  localparam int FractionBits = 16;
  localparam int DataW        = 32;
  localparam int LimW         = 31;
  localparam int MagW         = 32;
  localparam int RatioW       = FractionBits + 1;
  localparam int QDepth       = 2;

  typedef struct packed {
    logic signed [DataW-1:0] x_6;
    logic signed [DataW-1:0] x_5;
    logic signed [DataW-1:0] x_4;
    logic signed [DataW-1:0] x_3;
    logic signed [DataW-1:0] x_2;
    logic signed [DataW-1:0] x_1;
    logic signed [DataW-1:0] x_0;
  } in_item_t;

  typedef struct packed {
    logic                    was_scaled;
    logic signed [DataW-1:0] y_6;
    logic signed [DataW-1:0] y_5;
    logic signed [DataW-1:0] y_4;
    logic signed [DataW-1:0] y_3;
    logic signed [DataW-1:0] y_2;
    logic signed [DataW-1:0] y_1;
    logic signed [DataW-1:0] y_0;
  } out_item_t;

  typedef logic [VecMax-1:0][LimW-1:0] limits_t;
  typedef logic [VecMax-1:0][DataW-1:0] vec_t;

  typedef struct packed {
    vec_t              x;
    logic              scale;
    logic [LimW-1:0]   lim;
    logic [MagW-1:0]   mag;
  } job_t;

  function automatic logic [MagW-1:0] mag_of(logic [DataW-1:0] v);
    return v[DataW-1] ? MagW'(~v + 1'b1) : v;
  endfunction

  function automatic vec_t unpack_in(in_item_t it);
    vec_t v;
    v[0] = it.x_0; v[1] = it.x_1; v[2] = it.x_2; v[3] = it.x_3;
    v[4] = it.x_4; v[5] = it.x_5; v[6] = it.x_6;
    return v;
  endfunction
endpackage
`default_nettype wire

### rtl/dpvs_front.sv
`default_nettype none
module dpvs_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire dpvs_pkg::in_item_t  item_i,
  input  wire dpvs_pkg::limits_t   limits_i,
  output logic                  job_valid_o,
  input  wire logic             job_ready_i,
  output dpvs_pkg::job_t        job_o
);
  import dpvs_pkg::*;
  localparam int ProdW = LimW + MagW;
  localparam int Levels = 3;
  localparam int Lanes = 8;

  // tournament: stage 0 takes magnitudes, stages 1..3 reduce 8->4->2->1
  logic [Levels:0]                  v_q;
  vec_t                             x_q [Levels+1];
  logic [Lanes-1:0]                 h_q [Levels+1];
  logic [Lanes-1:0][LimW-1:0]       l_q [Levels+1];
  logic [Lanes-1:0][MagW-1:0]       m_q [Levels+1];
  logic adv;

  assign adv = !job_valid_o || job_ready_i;
  assign full = !adv;
  assign job_valid_o = v_q[Levels];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[Levels-1:0], push};
  end

  vec_t xin;
  assign xin = unpack_in(item_i);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= xin;
      for (int i = 0; i < Lanes; i++) begin
        if (i < NumElements && i < VecMax) begin
          m_q[0][i] <= mag_of(xin[i]);
          l_q[0][i] <= limits_i[i];
          h_q[0][i] <= xin[i] != '0;
        end else begin
          m_q[0][i] <= MagW'(1);
          l_q[0][i] <= '0;
          h_q[0][i] <= 1'b0;
        end
      end
      for (int s = 1; s <= Levels; s++) begin
        x_q[s] <= x_q[s-1];
        for (int k = 0; k < (Lanes >> s); k++) begin
          logic a, b, pick_b;
          logic [ProdW-1:0] pa, pb;
          a  = h_q[s-1][2*k];
          b  = h_q[s-1][2*k+1];
          pb = ProdW'(l_q[s-1][2*k+1]) * ProdW'(m_q[s-1][2*k]);
          pa = ProdW'(l_q[s-1][2*k]) * ProdW'(m_q[s-1][2*k+1]);
          pick_b = b && (!a || pb < pa);
          h_q[s][k] <= a || b;
          l_q[s][k] <= pick_b ? l_q[s-1][2*k+1] : l_q[s-1][2*k];
          m_q[s][k] <= pick_b ? m_q[s-1][2*k+1] : m_q[s-1][2*k];
        end
        for (int k = (Lanes >> s); k < Lanes; k++) begin
          h_q[s][k] <= 1'b0;
          l_q[s][k] <= '0;
          m_q[s][k] <= MagW'(1);
        end
      end
    end
  end

  always_comb begin
    job_o.x     = x_q[Levels];
    job_o.lim   = l_q[Levels][0];
    job_o.mag   = m_q[Levels][0];
    job_o.scale = h_q[Levels][0] && (MagW'(l_q[Levels][0]) < m_q[Levels][0]);
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && !job_ready_i |=> job_valid_o && $stable(job_o));
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job_o.scale |-> job_o.mag != '0);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> job_valid_o);
endmodule
`default_nettype wire

### rtl/dpvs_queue.sv
`default_nettype none
module dpvs_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  input  wire dpvs_pkg::job_t wr_data_i,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i,
  output dpvs_pkg::job_t      rd_data_o
);
  import dpvs_pkg::*;
  job_t mem_q [QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != 2'(QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) if (wr) mem_q[wp_q] <= wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(QDepth));
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> cnt_q == $past(cnt_q) + 2'd1);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == 2'(QDepth)) |-> wp_q == rp_q);
endmodule
`default_nettype wire

### rtl/dpvs_back.sv
`default_nettype none
module dpvs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  output logic                job_ready_o,
  input  wire dpvs_pkg::job_t job_i,
  output logic                empty,
  input  wire logic           pop,
  output dpvs_pkg::out_item_t item_o
);
  import dpvs_pkg::*;
  localparam int Steps = RatioW;
  localparam int RemW = MagW + 1;
  localparam int PW = MagW + RatioW;

  // restoring divider, one quotient bit per stage, then multiply and output
  logic [Steps+1:0]      v_q;
  vec_t                  x_q   [Steps+2];
  logic                  s_q   [Steps+2];
  logic [MagW-1:0]       d_q   [Steps+1];
  logic [RemW-1:0]       r_q   [Steps+1];
  logic [RatioW-1:0]     q_q   [Steps+1];
  logic [LimW-1:0]       n_q   [Steps+1];
  logic [PW-1:0]         p_q   [VecMax];
  logic [VecMax-1:0]     neg_q;
  logic adv;

  assign adv = empty || pop;
  assign job_ready_o = adv;
  assign empty = !v_q[Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[Steps:0], job_valid_i};
  end

  // lim < mag when scaling, so lim >> 1 is a valid partial remainder
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= job_i.x; s_q[0] <= job_i.scale;
      d_q[0] <= job_i.mag; n_q[0] <= job_i.lim;
      r_q[0] <= RemW'(job_i.lim >> 1); q_q[0] <= '0;
      for (int s = 1; s <= Steps; s++) begin
        logic [RemW-1:0] t;
        logic [LimW+FractionBits-1:0] num;
        num = {n_q[s-1], {FractionBits{1'b0}}};
        t = {r_q[s-1][RemW-2:0], num[FractionBits+1-s]};
        x_q[s] <= x_q[s-1]; s_q[s] <= s_q[s-1];
        d_q[s] <= d_q[s-1]; n_q[s] <= n_q[s-1];
        if (t >= RemW'(d_q[s-1])) begin
          r_q[s] <= t - RemW'(d_q[s-1]);
          q_q[s] <= {q_q[s-1][RatioW-2:0], 1'b1};
        end else begin
          r_q[s] <= t;
          q_q[s] <= {q_q[s-1][RatioW-2:0], 1'b0};
        end
      end
      x_q[Steps+1] <= x_q[Steps]; s_q[Steps+1] <= s_q[Steps];
      for (int i = 0; i < VecMax; i++) begin
        neg_q[i] <= x_q[Steps][i][DataW-1];
        p_q[i] <= PW'(mag_of(x_q[Steps][i])) * PW'(q_q[Steps]);
      end
    end
  end

  vec_t y;
  always_comb begin
    for (int i = 0; i < VecMax; i++) begin
      logic [PW-1:0] r;
      r = neg_q[i] ? (p_q[i] + PW'((1 << FractionBits) - 1)) >> FractionBits
                   : p_q[i] >> FractionBits;
      if (i >= NumElements) y[i] = '0;
      else if (s_q[Steps+1]) y[i] = neg_q[i] ? DataW'(~r + 1'b1) : DataW'(r);
      else y[i] = x_q[Steps+1][i];
    end
    item_o.y_0 = y[0]; item_o.y_1 = y[1]; item_o.y_2 = y[2]; item_o.y_3 = y[3];
    item_o.y_4 = y[4]; item_o.y_5 = y[5]; item_o.y_6 = y[6];
    item_o.was_scaled = s_q[Steps+1];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(item_o));
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !item_o.was_scaled && NumElements > 0 |-> item_o.y_0 == x_q[Steps+1][0]);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ready_o == (empty || pop));
endmodule
`default_nettype wire

### rtl/direction_preserving_vector_saturator_unit.sv
`default_nettype none
// Direction-preserving vector saturator.
// Input queue side: present a vector of seven signed Q15.16 values on
// item_i and raise push; the request is taken on a clock edge where full
// is low. Result queue side: while empty is low item_o holds the oldest
// result (scaled vector and was_scaled); pop takes it.
// One request per cycle is sustained while pop is held high. A result
// passes through 4 front stages (magnitudes plus a three-level
// cross-multiply tournament that finds the smallest limit/|x|), one entry
// in the two-entry queue, then 19 back stages: an input stage, one per
// quotient bit of the 17-bit ratio divider, and one for the element
// multiplies.
// Limits are written over the APB port at byte address 4*i and read back;
// reset sets every limit to 0x7FFFFFFF and flushes all in-flight requests.
// When pop is held low the back pipeline freezes, the queue fills and
// then the front freezes and full rises; nothing is lost.
module direction_preserving_vector_saturator_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire dpvs_pkg::in_item_t   item_i,
  output logic                      empty,
  input  wire logic                 pop,
  output dpvs_pkg::out_item_t       item_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import dpvs_pkg::*;
  limits_t lim_q;
  logic [2:0] idx;
  logic fv, fr, bv, br;
  job_t fj, bj;

  assign pready = 1'b1;
  assign idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VecMax; i++) lim_q[i] <= {LimW{1'b1}};
    end else if (psel && penable && pwrite && idx < 3'(VecMax)) begin
      lim_q[idx] <= pwdata[LimW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx < 3'(VecMax)) prdata = {1'b0, lim_q[idx]};
  end

  dpvs_front u_front (.clk_i, .rst_ni, .push, .full, .item_i, .limits_i(lim_q),
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fj));
  dpvs_queue u_queue (.clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr),
    .wr_data_i(fj), .rd_valid_o(bv), .rd_ready_i(br), .rd_data_o(bj));
  dpvs_back u_back (.clk_i, .rst_ni, .job_valid_i(bv), .job_ready_o(br),
    .job_i(bj), .empty, .pop, .item_o);
endmodule
`default_nettype wire
